// File: src/onewire_temp_sensor_reader_unit_assert.svh
// assertion macros shared by the single-wire reader rtl
`ifndef ONEWIRE_TEMP_SENSOR_READER_UNIT_ASSERT_SVH
`define ONEWIRE_TEMP_SENSOR_READER_UNIT_ASSERT_SVH

// antecedent in this cycle implies consequent in the next cycle
`define OTSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// antecedent implies consequent in the same cycle
`define OTSR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: src/otsr_pkg.sv
// types and constants of the single-wire temperature reader
package otsr_pkg;

  // sequencer steps
  typedef enum logic [4:0] {
    ST_IDLE, ST_R1_LOW, ST_R1_WAIT, ST_R1_TAIL, ST_GAP,
    ST_W0_LOW, ST_W0_REL, ST_W1_LOW, ST_W1_REL, ST_CONV,
    ST_R2_LOW, ST_R2_WAIT, ST_R2_TAIL, ST_W2_LOW, ST_W2_REL,
    ST_W3_LOW, ST_W3_REL, ST_RD0_LOW, ST_RD0_REL, ST_RD1_LOW, ST_RD1_REL
  } step_e;

  // bus commands
  localparam logic [7:0] CMD_SKIP_ROM    = 8'hCC;
  localparam logic [7:0] CMD_CONVERT     = 8'h44;
  localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_TAIL    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT          = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_ONE_LOW = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_READ_LOW      = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_GAP     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CONV_WAIT     = 4'd7;

  localparam int unsigned CFG_DATA_W = 20;

  typedef struct packed {
    logic [9:0]  reset_low;
    logic [9:0]  presence_wait;
    logic [9:0]  reset_tail;
    logic [7:0]  slot;
    logic [7:0]  write_one_low;
    logic [7:0]  read_low;
    logic [19:0] reset_gap;
    logic [19:0] conv_wait;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    reset_low:     10'd480,
    presence_wait: 10'd80,
    reset_tail:    10'd400,
    slot:          8'd60,
    write_one_low: 8'd1,
    read_low:      8'd2,
    reset_gap:     20'd1000,
    conv_wait:     20'd800000
  };

  // result of one tick as seen after the step
  typedef struct packed {
    logic        drive_low;
    logic        busy;
    logic        reading_valid;
    logic [15:0] reading;
  } res_t;

  // fahrenheit: (raw*9 + 2560) / 5, division by reciprocal multiply
  localparam logic signed [19:0] FAHR_OFFSET = 20'sd2560;
  localparam logic [19:0]        FAHR_MAGIC  = 20'd838861;
  localparam int unsigned        FAHR_SHIFT  = 22;

endpackage

// File: src/otsr_fahr.sv
// celsius sixteenths to fahrenheit sixteenths, truncated toward zero
module otsr_fahr (
  input  logic signed [15:0] celsius_i,
  output logic signed [16:0] fahrenheit_o
);

  logic signed [19:0] cel_ext;
  logic signed [19:0] scaled;
  logic               neg;
  logic [19:0]        mag_full;
  logic [18:0]        mag;
  logic [38:0]        prod;
  logic [16:0]        quo;

  assign cel_ext  = 20'(celsius_i);
  assign scaled   = (cel_ext <<< 3) + cel_ext + otsr_pkg::FAHR_OFFSET;
  assign neg      = scaled[19];
  assign mag_full = neg ? 20'(-scaled) : 20'(scaled);
  assign mag      = mag_full[18:0];
  // exact for all magnitudes below 2**19
  assign prod     = 39'(mag) * 39'(otsr_pkg::FAHR_MAGIC);
  assign quo      = prod[otsr_pkg::FAHR_SHIFT +: 17];
  assign fahrenheit_o = neg ? -$signed(quo) : $signed(quo);

endmodule

// File: src/otsr_seq.sv
// bus sequencer: phase timing, command bits, read shifter and reading register
`include "onewire_temp_sensor_reader_unit_assert.svh"

module otsr_seq #(
  parameter int unsigned TICK_COUNTER_WIDTH = 20
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_en_i,
  input  logic             mode_i,
  input  logic             level_i,
  input  otsr_pkg::cfg_t   cfg_i,
  output otsr_pkg::res_t   res_o
);

  localparam int unsigned CW = TICK_COUNTER_WIDTH;

  otsr_pkg::step_e step_q, step_d;
  logic [CW-1:0]   ticks_q, ticks_d;
  logic [2:0]      bit_q, bit_d, bit_next;
  logic [7:0]      shift_q, shift_d, shift_cur;
  logic [7:0]      first_q, first_d;
  logic [15:0]     reading_q, reading_d;
  logic            done;

  logic [7:0]      cmd;
  logic            cmd_bit;
  logic [19:0]     len_base;
  logic [32:0]     len_wide, max_wide, len_clamp;
  logic [CW-1:0]   len;
  logic [CW:0]     ticks_inc;
  logic            phase_end;
  logic            rd_rel;

  function automatic logic [7:0] command_of(otsr_pkg::step_e s);
    case (s)
      otsr_pkg::ST_W0_LOW, otsr_pkg::ST_W0_REL: command_of = otsr_pkg::CMD_SKIP_ROM;
      otsr_pkg::ST_W1_LOW, otsr_pkg::ST_W1_REL: command_of = otsr_pkg::CMD_CONVERT;
      otsr_pkg::ST_W2_LOW, otsr_pkg::ST_W2_REL: command_of = otsr_pkg::CMD_SKIP_ROM;
      otsr_pkg::ST_W3_LOW, otsr_pkg::ST_W3_REL: command_of = otsr_pkg::CMD_READ_SCRATCH;
      default: command_of = 8'h00;
    endcase
  endfunction

  function automatic logic drives_low(otsr_pkg::step_e s);
    case (s)
      otsr_pkg::ST_R1_LOW, otsr_pkg::ST_R2_LOW, otsr_pkg::ST_W0_LOW,
      otsr_pkg::ST_W1_LOW, otsr_pkg::ST_W2_LOW, otsr_pkg::ST_W3_LOW,
      otsr_pkg::ST_RD0_LOW, otsr_pkg::ST_RD1_LOW: drives_low = 1'b1;
      default: drives_low = 1'b0;
    endcase
  endfunction

  assign cmd     = command_of(step_q);
  assign cmd_bit = cmd[bit_q];
  assign rd_rel  = (step_q == otsr_pkg::ST_RD0_REL) || (step_q == otsr_pkg::ST_RD1_REL);

  always_comb begin
    case (step_q)
      otsr_pkg::ST_R1_LOW, otsr_pkg::ST_R2_LOW:   len_base = 20'(cfg_i.reset_low);
      otsr_pkg::ST_R1_WAIT, otsr_pkg::ST_R2_WAIT: len_base = 20'(cfg_i.presence_wait);
      otsr_pkg::ST_R1_TAIL, otsr_pkg::ST_R2_TAIL: len_base = 20'(cfg_i.reset_tail);
      otsr_pkg::ST_GAP:                           len_base = cfg_i.reset_gap;
      otsr_pkg::ST_CONV:                          len_base = cfg_i.conv_wait;
      otsr_pkg::ST_W0_LOW, otsr_pkg::ST_W1_LOW,
      otsr_pkg::ST_W2_LOW, otsr_pkg::ST_W3_LOW: begin
        len_base = cmd_bit ? 20'(cfg_i.write_one_low) : 20'(cfg_i.slot);
      end
      otsr_pkg::ST_W0_REL, otsr_pkg::ST_W1_REL,
      otsr_pkg::ST_W2_REL, otsr_pkg::ST_W3_REL: begin
        // a zero bit gets a single recovery tick
        len_base = cmd_bit ? 20'(cfg_i.slot) : 20'd1;
      end
      otsr_pkg::ST_RD0_LOW, otsr_pkg::ST_RD1_LOW: len_base = 20'(cfg_i.read_low);
      default:                                    len_base = 20'(cfg_i.slot);
    endcase
  end

  // zero length counts as one tick, long lengths clip to the counter range
  assign len_wide  = (len_base == 20'd0) ? 33'd1 : 33'(len_base);
  assign max_wide  = (33'd1 << CW) - 33'd1;
  assign len_clamp = (len_wide > max_wide) ? max_wide : len_wide;
  assign len       = len_clamp[CW-1:0];
  assign ticks_inc = {1'b0, ticks_q} + {{CW{1'b0}}, 1'b1};
  assign phase_end = ticks_inc >= {1'b0, len};
  assign bit_next  = bit_q + 3'd1;

  always_comb begin
    step_d    = step_q;
    ticks_d   = ticks_q;
    bit_d     = bit_q;
    shift_cur = shift_q;
    shift_d   = shift_q;
    first_d   = first_q;
    reading_d = reading_q;
    done      = 1'b0;
    if (mode_i) begin
      if (step_q == otsr_pkg::ST_IDLE) begin
        step_d  = otsr_pkg::ST_R1_LOW;
        ticks_d = '0;
        bit_d   = 3'd0;
        shift_d = 8'd0;
      end
    end else if (step_q != otsr_pkg::ST_IDLE) begin
      // sample on the first released tick of a read slot
      if (rd_rel && (ticks_q == '0) && level_i) begin
        shift_cur[bit_q] = 1'b1;
      end
      shift_d = shift_cur;
      if (phase_end) begin
        ticks_d = '0;
        case (step_q)
          otsr_pkg::ST_R1_LOW:  step_d = otsr_pkg::ST_R1_WAIT;
          otsr_pkg::ST_R1_WAIT: step_d = otsr_pkg::ST_R1_TAIL;
          otsr_pkg::ST_R1_TAIL: begin
            step_d = (cfg_i.reset_gap == 20'd0) ? otsr_pkg::ST_W0_LOW : otsr_pkg::ST_GAP;
          end
          otsr_pkg::ST_GAP:     step_d = otsr_pkg::ST_W0_LOW;
          otsr_pkg::ST_CONV:    step_d = otsr_pkg::ST_R2_LOW;
          otsr_pkg::ST_R2_LOW:  step_d = otsr_pkg::ST_R2_WAIT;
          otsr_pkg::ST_R2_WAIT: step_d = otsr_pkg::ST_R2_TAIL;
          otsr_pkg::ST_R2_TAIL: step_d = otsr_pkg::ST_W2_LOW;
          otsr_pkg::ST_W0_LOW:  step_d = otsr_pkg::ST_W0_REL;
          otsr_pkg::ST_W1_LOW:  step_d = otsr_pkg::ST_W1_REL;
          otsr_pkg::ST_W2_LOW:  step_d = otsr_pkg::ST_W2_REL;
          otsr_pkg::ST_W3_LOW:  step_d = otsr_pkg::ST_W3_REL;
          otsr_pkg::ST_RD0_LOW: step_d = otsr_pkg::ST_RD0_REL;
          otsr_pkg::ST_RD1_LOW: step_d = otsr_pkg::ST_RD1_REL;
          otsr_pkg::ST_W0_REL: begin
            bit_d  = bit_next;
            step_d = (bit_next != 3'd0) ? otsr_pkg::ST_W0_LOW : otsr_pkg::ST_W1_LOW;
          end
          otsr_pkg::ST_W1_REL: begin
            bit_d  = bit_next;
            step_d = (bit_next != 3'd0) ? otsr_pkg::ST_W1_LOW : otsr_pkg::ST_CONV;
          end
          otsr_pkg::ST_W2_REL: begin
            bit_d  = bit_next;
            step_d = (bit_next != 3'd0) ? otsr_pkg::ST_W2_LOW : otsr_pkg::ST_W3_LOW;
          end
          otsr_pkg::ST_W3_REL: begin
            bit_d = bit_next;
            if (bit_next != 3'd0) begin
              step_d = otsr_pkg::ST_W3_LOW;
            end else begin
              step_d  = otsr_pkg::ST_RD0_LOW;
              shift_d = 8'd0;
            end
          end
          otsr_pkg::ST_RD0_REL: begin
            bit_d = bit_next;
            if (bit_next != 3'd0) begin
              step_d = otsr_pkg::ST_RD0_LOW;
            end else begin
              first_d = shift_cur;
              shift_d = 8'd0;
              step_d  = otsr_pkg::ST_RD1_LOW;
            end
          end
          otsr_pkg::ST_RD1_REL: begin
            bit_d = bit_next;
            if (bit_next != 3'd0) begin
              step_d = otsr_pkg::ST_RD1_LOW;
            end else begin
              reading_d = {shift_cur, first_q};
              step_d    = otsr_pkg::ST_IDLE;
              done      = 1'b1;
            end
          end
          default: step_d = otsr_pkg::ST_IDLE;
        endcase
      end else begin
        ticks_d = ticks_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= otsr_pkg::ST_IDLE;
      ticks_q   <= '0;
      bit_q     <= 3'd0;
      shift_q   <= 8'd0;
      first_q   <= 8'd0;
      reading_q <= 16'd0;
    end else if (step_en_i) begin
      step_q    <= step_d;
      ticks_q   <= ticks_d;
      bit_q     <= bit_d;
      shift_q   <= shift_d;
      first_q   <= first_d;
      reading_q <= reading_d;
    end
  end

  assign res_o.drive_low     = drives_low(step_d);
  assign res_o.busy          = (step_d != otsr_pkg::ST_IDLE);
  assign res_o.reading_valid = done;
  assign res_o.reading       = reading_d;

  `OTSR_ASSERT_NEXT(a_seq_hold, !step_en_i, $stable(step_q) && $stable(ticks_q) && $stable(reading_q), "sequencer moved without a beat")
  `OTSR_ASSERT_NEXT(a_done_idle, step_en_i && done, step_q == otsr_pkg::ST_IDLE, "reading done but sequencer not idle")
  `OTSR_ASSERT_NEXT(a_idle_tick, step_en_i && !mode_i && (step_q == otsr_pkg::ST_IDLE), (step_q == otsr_pkg::ST_IDLE) && (ticks_q == '0), "idle tick changed state")

endmodule

// File: src/onewire_temp_sensor_reader_unit.sv
// top level of the single-wire temperature reader: config, input and result registers
//
// Each input beat is one microsecond of bus time (tuser 0) or a start command
// (tuser 1); every beat returns exactly one result beat, one per clock when both
// sides keep flowing; a beat goes through the input register, then the result register.
// It is held in the input register, stepped through the bus sequencer (reset pulse,
// skip-ROM, convert, conversion wait, reset, skip-ROM, read scratchpad, two bytes
// LSB first) combinationally, and the drive level, busy flag, completion flag and
// the last reading in celsius and fahrenheit sixteenths land in the result register.
// The input side takes a beat while a result waits if the input register is empty or
// the result register frees in the same cycle. The user must write timing registers
// through the cfg port only while no beat is in flight; the block does not enforce it.
`include "onewire_temp_sensor_reader_unit_assert.svh"

module onewire_temp_sensor_reader_unit #(
  parameter int unsigned TICK_COUNTER_WIDTH = 20
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // config write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [otsr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [otsr_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // input stream
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [7:0]                         s_axis_tdata_i,  // [0] line_level
  input  logic                               s_axis_tuser_i,  // [0] mode
  // result stream
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [0] line_drive_low, [1] busy_res, [17:2] celsius_sixteenths,
  // [34:18] fahrenheit_sixteenths
  output logic [39:0]                        m_axis_tdata_o,
  output logic                               m_axis_tuser_o   // [0] reading_valid
);

  otsr_pkg::cfg_t cfg_q;

  logic in_vld_q, in_mode_q, in_level_q;
  logic adv;

  otsr_pkg::res_t    res;
  logic signed [16:0] fahr;

  logic               out_vld_q;
  logic               drive_q, busy_q, valid_q;
  logic [15:0]        cel_q;
  logic signed [16:0] fahr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= otsr_pkg::CFG_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        otsr_pkg::REG_RESET_LOW:     cfg_q.reset_low     <= cfg_data_i[9:0];
        otsr_pkg::REG_PRESENCE_WAIT: cfg_q.presence_wait <= cfg_data_i[9:0];
        otsr_pkg::REG_RESET_TAIL:    cfg_q.reset_tail    <= cfg_data_i[9:0];
        otsr_pkg::REG_SLOT:          cfg_q.slot          <= cfg_data_i[7:0];
        otsr_pkg::REG_WRITE_ONE_LOW: cfg_q.write_one_low <= cfg_data_i[7:0];
        otsr_pkg::REG_READ_LOW:      cfg_q.read_low      <= cfg_data_i[7:0];
        otsr_pkg::REG_RESET_GAP:     cfg_q.reset_gap     <= cfg_data_i[19:0];
        otsr_pkg::REG_CONV_WAIT:     cfg_q.conv_wait     <= cfg_data_i[19:0];
        default: ;
      endcase
    end
  end

  // beat moves from input register to result register
  assign adv             = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_mode_q  <= s_axis_tuser_i;
      in_level_q <= s_axis_tdata_i[0];
    end
  end

  otsr_seq #(
    .TICK_COUNTER_WIDTH(TICK_COUNTER_WIDTH)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (adv),
    .mode_i    (in_mode_q),
    .level_i   (in_level_q),
    .cfg_i     (cfg_q),
    .res_o     (res)
  );

  otsr_fahr u_fahr (
    .celsius_i    ($signed(res.reading)),
    .fahrenheit_o (fahr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      drive_q <= res.drive_low;
      busy_q  <= res.busy;
      valid_q <= res.reading_valid;
      cel_q   <= res.reading;
      fahr_q  <= fahr;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {5'd0, fahr_q, cel_q, busy_q, drive_q};
  assign m_axis_tuser_o  = valid_q;

  `OTSR_ASSERT_NEXT(a_in_hold, in_vld_q && !adv, in_vld_q && $stable(in_mode_q) && $stable(in_level_q), "pending input beat lost")
  `OTSR_ASSERT_NEXT(a_out_load, adv, out_vld_q, "stepped beat missing from result register")
  `OTSR_ASSERT_NEXT(a_out_hold, out_vld_q && !m_axis_tready_i, out_vld_q && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "stalled result beat changed")

endmodule
